FILE: design/gka_pkg.sv
// ----------------------------------------------------------------------------
// gka_pkg: shared constants and functions for the k-space gridding accumulator
// Command codes, register indexes, item layout and the fixed-point helpers.
// ----------------------------------------------------------------------------
package gka_pkg;

   localparam int GRID_SIZE_DEF  = 64;
   localparam int KERNEL_LEN_DEF = 512;

   // command codes (tuser)
   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_ACCUM = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // register indexes
   localparam logic REG_DIMS       = 1'b0;
   localparam logic REG_HALF_WIDTH = 1'b1;

   localparam logic [1:0] DIMS_2D = 2'd2;

   // field widths
   localparam int COORD_W  = 14;
   localparam int SAMPLE_W = 16;
   localparam int WEIGHT_W = 16;
   localparam int TIDX_W   = 9;
   localparam int TVAL_W   = 16;
   localparam int ADDR_W   = 18;
   localparam int HW_W     = 12;
   localparam int CELL_W   = 32;
   localparam int RANGE_W  = 8;   // grid coordinate of a cell

   // request tdata layout, lowest bit first
   localparam int X_LSB   = 0;
   localparam int Y_LSB   = X_LSB + COORD_W;
   localparam int Z_LSB   = Y_LSB + COORD_W;
   localparam int RE_LSB  = Z_LSB + COORD_W;
   localparam int IM_LSB  = RE_LSB + SAMPLE_W;
   localparam int W_LSB   = IM_LSB + SAMPLE_W;
   localparam int TI_LSB  = W_LSB + WEIGHT_W;
   localparam int TV_LSB  = TI_LSB + TIDX_W;
   localparam int AD_LSB  = TV_LSB + TVAL_W;
   localparam int REQ_BITS = AD_LSB + ADDR_W;
   localparam int REQ_W   = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_W   = 2 * CELL_W;

   // shared multiplier operand and product widths
   localparam int MA_W = 34;
   localparam int MB_W = 27;
   localparam int MP_W = MA_W + MB_W;

   // first cell at or above c-h, in grid units
   function automatic logic [RANGE_W-1:0] axis_start(input logic [COORD_W-1:0] c,
                                                     input logic [HW_W-1:0] h);
      logic signed [COORD_W+1:0] lo;
      logic [COORD_W+1:0]        up;
      lo = $signed({2'b00, c}) - $signed({4'b0000, h});
      up = lo + (COORD_W+2)'(255);
      if (lo <= 0) return '0;
      else return up[RANGE_W+7:8];
   endfunction

   // last cell at or below c+h, clipped to the grid
   function automatic logic [RANGE_W-1:0] axis_end(input logic [COORD_W-1:0] c,
                                                   input logic [HW_W-1:0] h,
                                                   input logic [RANGE_W-1:0] gmax);
      logic [COORD_W:0] hi;
      hi = {1'b0, c} + {3'b000, h};
      if (hi[COORD_W:8] > {2'b00, gmax}) return gmax;
      else return RANGE_W'(hi[COORD_W:8]);
   endfunction

   // add a shifted contribution with saturation to 32 bits
   function automatic logic [CELL_W-1:0] sat_add(input logic signed [CELL_W-1:0] a,
                                                 input logic signed [20:0] b);
      logic signed [CELL_W:0] s;
      s = $signed({a[CELL_W-1], a}) + (CELL_W+1)'(b);
      if (s > $signed({1'b0, 1'b0, {(CELL_W-1){1'b1}}})) return {1'b0, {(CELL_W-1){1'b1}}};
      else if (s < $signed({1'b1, 1'b1, {(CELL_W-1){1'b0}}}))
         return {1'b1, {(CELL_W-1){1'b0}}};
      else return s[CELL_W-1:0];
   endfunction

endpackage

FILE: design/kspace_gridding_accumulator.sv
// Kernel load writes the table on accept. Cell read: ST_RD, then ST_RD2 holds
// until the output register is free. Accumulate: ST_PRE, ST_PIM, ST_HH and
// ST_RANGE, then per cell ST_DX, ST_DY, ST_DZ, ST_CHK; within the radius ST_RHS,
// a bit-serial root search over QW index bits (10 at KERNEL_LEN 512) on the one
// shared multiplier, ST_KI, ST_MRE, ST_MIM, ST_WR. One item at a time. Reset:
// synchronous; the grid is then cleared one cell a cycle with req_tready low.
// ----------------------------------------------------------------------------
// kspace_gridding_accumulator
// Spreads weighted complex samples over grid cells using a radial kernel table.
// ----------------------------------------------------------------------------
module kspace_gridding_accumulator import gka_pkg::*; #(
   parameter int GRID_SIZE  = GRID_SIZE_DEF,
   parameter int KERNEL_LEN = KERNEL_LEN_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // coord_x, coord_y, coord_z, sample_re, sample_im, density_weight,
   // table_index, table_value, cell_address
   input  logic [REQ_W-1:0]  req_tdata,
   input  logic [1:0]        req_tuser,   // command
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata,   // cell_re, cell_im
   input  logic              csr_we,
   input  logic              csr_addr,
   input  logic [HW_W-1:0]   csr_wdata
);

   localparam int CELL_COUNT = GRID_SIZE * GRID_SIZE * GRID_SIZE;
   localparam int CAW    = $clog2(CELL_COUNT);
   localparam int KAW    = $clog2(KERNEL_LEN);
   localparam int LM1    = KERNEL_LEN - 1;
   localparam int QW     = $clog2(2 * LM1);
   localparam int BW     = $clog2(QW);
   localparam int LM1SQ4 = 4 * LM1 * LM1;
   localparam logic [RANGE_W-1:0] GMAX = RANGE_W'(GRID_SIZE - 1);

   localparam logic [4:0] ST_CLEAR = 5'd0,  ST_IDLE = 5'd1,  ST_PRE = 5'd2,
                          ST_PIM   = 5'd3,  ST_HH   = 5'd4,  ST_RANGE = 5'd5,
                          ST_DX    = 5'd6,  ST_DY   = 5'd7,  ST_DZ = 5'd8,
                          ST_CHK   = 5'd9,  ST_RHS  = 5'd10, ST_SQM = 5'd11,
                          ST_SQS   = 5'd12, ST_SQC  = 5'd13, ST_KI = 5'd14,
                          ST_MRE   = 5'd15, ST_MIM  = 5'd16, ST_WR = 5'd17,
                          ST_RD    = 5'd18, ST_RD2  = 5'd19;

   logic [4:0]              state_ff, state_in;
   logic [1:0]              dims_ff;
   logic [HW_W-1:0]         hw_ff;
   logic [CAW-1:0]          clr_ff, clr_in;
   logic [COORD_W-1:0]      cx_ff, cy_ff, cz_ff, cx_in, cy_in, cz_in;
   logic signed [SAMPLE_W-1:0] sre_ff, sim_ff, sre_in, sim_in;
   logic [WEIGHT_W-1:0]     w_ff, w_in;
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   logic signed [31:0]      pre_ff, pim_ff, pre_in, pim_in;
   logic [23:0]             hh_ff, hh_in;
   logic [RANGE_W-1:0]      x_ff, y_ff, z_ff, x_in, y_in, z_in;
   logic [RANGE_W-1:0]      sx_ff, sy_ff, ex_ff, ey_ff, ez_ff;
   logic [RANGE_W-1:0]      sx_in, sy_in, ex_in, ey_in, ez_in;
   logic [25:0]             d2_ff, d2_in, d2_tot;
   logic [51:0]             rhs_ff, rhs_in;
   logic [QW-1:0]           q_ff, q_in, trial;
   logic [BW-1:0]           bit_ff, bit_in;
   logic [CELL_W-1:0]       nre_ff, nre_in;
   logic                    inr_ff, inr_in;
   logic                    rspv_ff, rspv_in;
   logic [RSP_W-1:0]        rspd_ff, rspd_in;

   logic signed [MA_W-1:0]  mul_a;
   logic signed [MB_W-1:0]  mul_b;
   logic signed [MP_W-1:0]  prod_ff;

   logic [63:0]             grid_mem [CELL_COUNT];
   logic [15:0]             kern_mem [KERNEL_LEN];
   logic                    g_we, g_re, k_re;
   logic [CAW-1:0]          g_waddr, g_raddr, cell_idx;
   logic [63:0]             g_wdata, g_rdata_ff;
   logic [KAW-1:0]          k_raddr;
   logic [15:0]             k_rdata_ff;

   logic                    accept;
   logic [1:0]              cmd;
   logic [TIDX_W-1:0]       req_ti;
   logic [QW:0]             q_inc;
   logic [KAW-1:0]          ki;
   logic signed [17:0]      dx, dy, dz;
   logic [RANGE_W-1:0]      sz_c, ex_c, ey_c, ez_c, sx_c, sy_c;
   logic [31:0]             addr_ext;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign cmd        = req_tuser;
   assign req_ti     = req_tdata[TI_LSB +: TIDX_W];
   assign rsp_tvalid = rspv_ff;
   assign rsp_tdata  = rspd_ff;
   assign addr_ext   = {{(32-ADDR_W){1'b0}}, addr_ff};

   assign dx = $signed({2'b00, x_ff, 8'h00}) - $signed({4'b0000, cx_ff});
   assign dy = $signed({2'b00, y_ff, 8'h00}) - $signed({4'b0000, cy_ff});
   assign dz = $signed({2'b00, z_ff, 8'h00}) - $signed({4'b0000, cz_ff});
   assign d2_tot = d2_ff + prod_ff[25:0];
   assign trial  = q_ff | (QW'(1) << bit_ff);
   assign q_inc  = {1'b0, q_ff} + (QW+1)'(1);
   assign ki     = (q_inc[QW:1] > (QW)'(LM1)) ? KAW'(LM1) : KAW'(q_inc[QW:1]);
   assign cell_idx = CAW'((32'(z_ff) * GRID_SIZE + 32'(y_ff)) * GRID_SIZE + 32'(x_ff));

   assign sx_c = axis_start(cx_ff, hw_ff);
   assign sy_c = axis_start(cy_ff, hw_ff);
   assign sz_c = axis_start(cz_ff, hw_ff);
   assign ex_c = axis_end(cx_ff, hw_ff, GMAX);
   assign ey_c = axis_end(cy_ff, hw_ff, GMAX);
   assign ez_c = axis_end(cz_ff, hw_ff, GMAX);

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_PRE: begin
            mul_a = MA_W'(sre_ff);
            mul_b = $signed({{(MB_W-WEIGHT_W){1'b0}}, w_ff});
         end
         ST_PIM: begin
            mul_a = MA_W'(sim_ff);
            mul_b = $signed({{(MB_W-WEIGHT_W){1'b0}}, w_ff});
         end
         ST_HH: begin
            mul_a = $signed({{(MA_W-HW_W){1'b0}}, hw_ff});
            mul_b = $signed({{(MB_W-HW_W){1'b0}}, hw_ff});
         end
         ST_DX: begin
            mul_a = MA_W'(dx);
            mul_b = MB_W'(dx);
         end
         ST_DY: begin
            mul_a = MA_W'(dy);
            mul_b = MB_W'(dy);
         end
         ST_DZ: begin
            mul_a = MA_W'(dz);
            mul_b = MB_W'(dz);
         end
         ST_CHK: begin
            mul_a = MA_W'(LM1SQ4);
            mul_b = $signed({1'b0, d2_tot});
         end
         ST_SQM: begin
            mul_a = $signed({{(MA_W-QW){1'b0}}, trial});
            mul_b = $signed({{(MB_W-HW_W){1'b0}}, hw_ff});
         end
         ST_SQS: begin
            mul_a = $signed({8'h00, prod_ff[25:0]});
            mul_b = $signed({1'b0, prod_ff[25:0]});
         end
         ST_MRE: begin
            mul_a = MA_W'(pre_ff);
            mul_b = $signed({{(MB_W-16){1'b0}}, k_rdata_ff});
         end
         ST_MIM: begin
            mul_a = MA_W'(pim_ff);
            mul_b = $signed({{(MB_W-16){1'b0}}, k_rdata_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff;
      sre_in = sre_ff; sim_in = sim_ff; w_in = w_ff; addr_in = addr_ff;
      pre_in = pre_ff; pim_in = pim_ff; hh_in = hh_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff;
      sx_in = sx_ff; sy_in = sy_ff; ex_in = ex_ff; ey_in = ey_ff; ez_in = ez_ff;
      d2_in = d2_ff; rhs_in = rhs_ff; q_in = q_ff; bit_in = bit_ff;
      nre_in = nre_ff; inr_in = inr_ff;
      rspv_in = rspv_ff && !rsp_tready;
      rspd_in = rspd_ff;
      g_we = 1'b0; g_waddr = cell_idx; g_wdata = '0;
      g_re = 1'b0; g_raddr = cell_idx;
      k_re = 1'b0; k_raddr = ki;
      case (state_ff)
         ST_CLEAR: begin
            g_we = 1'b1;
            g_waddr = clr_ff;
            clr_in = clr_ff + CAW'(1);
            if (clr_ff == CAW'(CELL_COUNT - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               cx_in = req_tdata[X_LSB +: COORD_W];
               cy_in = req_tdata[Y_LSB +: COORD_W];
               cz_in = (dims_ff == DIMS_2D) ? '0 : req_tdata[Z_LSB +: COORD_W];
               sre_in = req_tdata[RE_LSB +: SAMPLE_W];
               sim_in = req_tdata[IM_LSB +: SAMPLE_W];
               w_in = req_tdata[W_LSB +: WEIGHT_W];
               addr_in = req_tdata[AD_LSB +: ADDR_W];
               case (cmd)
                  CMD_ACCUM: state_in = ST_PRE;
                  CMD_READ:  state_in = ST_RD;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_PRE: state_in = ST_PIM;
         ST_PIM: begin
            pre_in = prod_ff[31:0];
            state_in = ST_HH;
         end
         ST_HH: begin
            pim_in = prod_ff[31:0];
            state_in = ST_RANGE;
         end
         ST_RANGE: begin
            hh_in = prod_ff[23:0];
            sx_in = sx_c; sy_in = sy_c;
            ex_in = ex_c; ey_in = ey_c;
            x_in = sx_c; y_in = sy_c;
            if (dims_ff == DIMS_2D) begin
               z_in = '0;
               ez_in = '0;
            end else begin
               z_in = sz_c;
               ez_in = ez_c;
            end
            // drop the sample when the box misses the grid
            if (sx_c > ex_c || sy_c > ey_c ||
                (dims_ff != DIMS_2D && sz_c > ez_c)) state_in = ST_IDLE;
            else state_in = ST_DX;
         end
         ST_DX: state_in = ST_DY;
         ST_DY: begin
            d2_in = prod_ff[25:0];
            state_in = ST_DZ;
         end
         ST_DZ: begin
            d2_in = d2_tot;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            d2_in = d2_tot;
            if (d2_tot >= {2'b00, hh_ff}) state_in = ST_WR;
            else state_in = ST_RHS;
         end
         ST_RHS: begin
            rhs_in = prod_ff[51:0];
            q_in = '0;
            bit_in = BW'(QW - 1);
            state_in = ST_SQM;
         end
         ST_SQM: state_in = ST_SQS;
         ST_SQS: state_in = ST_SQC;
         ST_SQC: begin
            // keep the trial bit while (q*h)^2 stays within 4*(L-1)^2*d2
            if (prod_ff[51:0] <= rhs_ff) q_in = trial;
            if (bit_ff == '0) state_in = ST_KI;
            else begin
               bit_in = bit_ff - BW'(1);
               state_in = ST_SQM;
            end
         end
         ST_KI: begin
            k_re = 1'b1;
            g_re = 1'b1;
            state_in = ST_MRE;
         end
         ST_MRE: state_in = ST_MIM;
         ST_MIM: begin
            nre_in = sat_add(g_rdata_ff[31:0], prod_ff[47:27]);
            state_in = ST_WR;
         end
         ST_WR: begin
            // cells outside the radius pass through here without a write
            if (d2_ff < {2'b00, hh_ff}) begin
               g_we = 1'b1;
               g_wdata = {sat_add(g_rdata_ff[63:32], prod_ff[47:27]), nre_ff};
            end
            state_in = ST_DX;
            if (x_ff != ex_ff) x_in = x_ff + RANGE_W'(1);
            else begin
               x_in = sx_ff;
               if (y_ff != ey_ff) y_in = y_ff + RANGE_W'(1);
               else begin
                  y_in = sy_ff;
                  if (z_ff != ez_ff) z_in = z_ff + RANGE_W'(1);
                  else state_in = ST_IDLE;
               end
            end
         end
         ST_RD: begin
            inr_in = addr_ext < 32'(CELL_COUNT);
            g_re = 1'b1;
            g_raddr = addr_ext[CAW-1:0];
            state_in = ST_RD2;
         end
         ST_RD2: begin
            // hold until the output register is free
            if (!rspv_ff) begin
               rspv_in = 1'b1;
               rspd_in = inr_ff ? g_rdata_ff : '0;
               g_we = inr_ff;
               g_waddr = addr_ext[CAW-1:0];
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rspv_ff <= 1'b0;
         dims_ff <= 2'd3;
         hw_ff <= HW_W'(512);
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rspv_ff <= rspv_in;
         if (csr_we && csr_addr == REG_DIMS) dims_ff <= csr_wdata[1:0];
         if (csr_we && csr_addr == REG_HALF_WIDTH) hw_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in;
      sre_ff <= sre_in; sim_ff <= sim_in; w_ff <= w_in; addr_ff <= addr_in;
      pre_ff <= pre_in; pim_ff <= pim_in; hh_ff <= hh_in;
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
      sx_ff <= sx_in; sy_ff <= sy_in; ex_ff <= ex_in; ey_ff <= ey_in; ez_ff <= ez_in;
      d2_ff <= d2_in; rhs_ff <= rhs_in; q_ff <= q_in; bit_ff <= bit_in;
      nre_ff <= nre_in; inr_ff <= inr_in; rspd_ff <= rspd_in;
      prod_ff <= mul_a * mul_b;
   end

   // grid store
   always_ff @(posedge clock) begin
      if (g_we) grid_mem[g_waddr] <= g_wdata;
      if (g_re) g_rdata_ff <= grid_mem[g_raddr];
   end

   // kernel table
   always_ff @(posedge clock) begin
      if (accept && cmd == CMD_LOAD &&
          {{(13-TIDX_W){1'b0}}, req_ti} < 13'(KERNEL_LEN))
         kern_mem[KAW'(req_ti)] <= req_tdata[TV_LSB +: TVAL_W];
      if (k_re) k_rdata_ff <= kern_mem[k_raddr];
   end

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_tready)
      else $error("ready while a command is in progress");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rspv_ff && !rsp_tready |=> rspv_ff && $stable(rspd_ff))
      else $error("pending cell item changed before it was taken");

   a_ki_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_KI |-> q_ff < QW'(2 * LM1))
      else $error("kernel index search out of range");

endmodule
